/* hw/rtl/rist_pkg.sv */
// Shared types and codes for the refcounted inode slot table.
// Used by rist_ctrl, rist_datapath and the top level; depends on nothing.
`default_nettype none

package rist_pkg;

	// Result status codes
	localparam logic [2:0] ST_HIT        = 3'd0;
	localparam logic [2:0] ST_LOAD       = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_STILL_USED = 3'd3;
	localparam logic [2:0] ST_WRITEBACK  = 3'd4;
	localparam logic [2:0] ST_IGNORED    = 3'd5;

	// Request function codes
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_COMMIT
	} state_t;

	// Outcome of the lookup stage
	typedef enum logic [2:0] {
		K_HIT,
		K_LOAD,
		K_FULL,
		K_PUT_USED,
		K_IGNORED
	} kind_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_stall;
	} dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/rist_ctrl.sv */
// Controller state machine for the slot table: sequences capture, lookup, commit.
// Depends on rist_pkg.
`default_nettype none

module rist_ctrl
	import rist_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t dp_status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!dp_status.out_stall) begin
					state_d = in_valid ? S_LOOKUP : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: take a new item when idle or while the current one commits
	always_comb begin
		in_ready    = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			S_COMMIT: begin
				in_ready   = !dp_status.out_stall;
				cmd.commit = !dp_status.out_stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.capture = in_valid && in_ready;
	end

endmodule

`default_nettype wire

/* hw/rtl/rist_datapath.sv */
// Datapath of the slot table: request register, object match array, count memory,
// count update and the result register. Depends on rist_pkg.
`default_nettype none

module rist_datapath
	import rist_pkg::*;
#(
	parameter int SLOTS       = 64,
	parameter int OBJECT_BITS = 8,
	parameter int COUNT_BITS  = 16,
	localparam int IDX_W      = $clog2(SLOTS)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ctrl_cmd_t              cmd,
	output dp_status_t                  dp_status,
	input  wire logic                   func,
	input  wire logic [OBJECT_BITS-1:0] object_number,
	input  wire logic [IDX_W-1:0]       slot_index,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [2:0]                  status,
	output logic [IDX_W-1:0]            slot_out,
	output logic [OBJECT_BITS-1:0]      object_out,
	output logic [COUNT_BITS-1:0]       count_out
);

	localparam logic [IDX_W:0]        SLOTS_W   = (IDX_W + 1)'(SLOTS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	// Request register
	logic                   func_q;
	logic [OBJECT_BITS-1:0] obj_q;
	logic [IDX_W-1:0]       sidx_q;

	// Slot state: in-use bits, object array, count memory
	logic [SLOTS-1:0]       used_q;
	logic [OBJECT_BITS-1:0] obj_tab_q [SLOTS];
	logic [COUNT_BITS-1:0]  cnt_mem [SLOTS];

	// Lookup stage registers
	kind_t                  kind_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [OBJECT_BITS-1:0] obj_s1;
	logic [COUNT_BITS-1:0]  cnt_s1;

	// Result register
	logic                   out_valid_q;
	logic [2:0]             status_q;
	logic [IDX_W-1:0]       slot_q;
	logic [OBJECT_BITS-1:0] object_q;
	logic [COUNT_BITS-1:0]  count_q;

	// Lookup logic
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic                   free_any;
	logic [IDX_W-1:0]       free_idx;
	logic                   in_range;
	logic                   put_used;
	kind_t                  kind_d;
	logic [IDX_W-1:0]       idx_d;
	logic [OBJECT_BITS-1:0] obj_d;

	// Commit logic
	logic [COUNT_BITS-1:0]  cnt_new;
	logic                   cnt_we;
	logic [2:0]             status_d;
	logic [IDX_W-1:0]       slot_d;
	logic [OBJECT_BITS-1:0] object_d;
	logic [COUNT_BITS-1:0]  count_d;

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			obj_q  <= object_number;
			sidx_q <= slot_index;
		end
	end

	// Match every slot in parallel; keep the lowest hit and the lowest free slot
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (used_q[i] && (obj_tab_q[i] == obj_q)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// Classify the request
	always_comb begin
		in_range = {1'b0, sidx_q} < SLOTS_W;
		put_used = in_range ? used_q[sidx_q] : 1'b0;
		obj_d    = obj_q;
		if (func_q == FUNC_PUT) begin
			idx_d  = sidx_q;
			kind_d = put_used ? K_PUT_USED : K_IGNORED;
			obj_d  = put_used ? obj_tab_q[sidx_q] : '0;
		end else if (hit) begin
			idx_d  = hit_idx;
			kind_d = K_HIT;
		end else if (free_any) begin
			idx_d  = free_idx;
			kind_d = K_LOAD;
		end else begin
			idx_d  = '0;
			kind_d = K_FULL;
		end
	end

	// Register the lookup outcome
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			kind_s1 <= kind_d;
			idx_s1  <= idx_d;
			obj_s1  <= obj_d;
		end
	end

	// Compute the new count and the result
	always_comb begin
		cnt_new  = cnt_s1;
		cnt_we   = 1'b0;
		status_d = ST_IGNORED;
		slot_d   = idx_s1;
		object_d = obj_s1;
		count_d  = '0;
		case (kind_s1)
			K_HIT: begin
				cnt_new  = (cnt_s1 == COUNT_MAX) ? cnt_s1 : cnt_s1 + COUNT_ONE;
				cnt_we   = 1'b1;
				status_d = ST_HIT;
				count_d  = cnt_new;
			end
			K_LOAD: begin
				cnt_new  = COUNT_ONE;
				cnt_we   = 1'b1;
				status_d = ST_LOAD;
				count_d  = COUNT_ONE;
			end
			K_FULL: begin
				status_d = ST_FULL;
				slot_d   = '0;
			end
			K_PUT_USED: begin
				cnt_new  = cnt_s1 - COUNT_ONE;
				cnt_we   = 1'b1;
				status_d = (cnt_new == '0) ? ST_WRITEBACK : ST_STILL_USED;
				count_d  = cnt_new;
			end
			default: begin
				status_d = ST_IGNORED;
				object_d = '0;
			end
		endcase
	end

	// Count memory: registered read during lookup, write on commit
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			cnt_s1 <= cnt_mem[idx_d];
		end
		if (cmd.commit && cnt_we) begin
			cnt_mem[idx_s1] <= cnt_new;
		end
	end

	// Object array: store the number when a slot is claimed
	always_ff @(posedge clk) begin
		if (cmd.commit && (kind_s1 == K_LOAD)) begin
			obj_tab_q[idx_s1] <= obj_s1;
		end
	end

	// In-use bits: set on claim, drop when the count reaches zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.commit) begin
			if (kind_s1 == K_LOAD) begin
				used_q[idx_s1] <= 1'b1;
			end else if ((kind_s1 == K_PUT_USED) && (cnt_new == '0)) begin
				used_q[idx_s1] <= 1'b0;
			end
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			object_q <= object_d;
			count_q  <= count_d;
		end
	end

	assign dp_status.out_stall = out_valid_q && !out_ready;
	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign slot_out            = slot_q;
	assign object_out          = object_q;
	assign count_out           = count_q;

endmodule

`default_nettype wire

/* hw/rtl/refcounted_inode_slot_table.sv */
// Top level of the refcounted inode slot table (get/put on an in-core inode cache).
// Instantiates rist_ctrl and rist_datapath; depends on rist_pkg.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   func, object_number, slot_index
//   out      out_valid / out_ready status, slot_out, object_out, count_out
//
// An item passes through lookup (parallel match of all slots, count memory read)
// and then commit (count update and write-back, result register load). The next
// item is captured while the current one commits, so lookup and commit alternate.
// Reset clears all in-use bits at once; no clearing pass is needed.
// A stalled result holds the commit stage; input is taken again once it drains.
`default_nettype none

module refcounted_inode_slot_table
	import rist_pkg::*;
#(
	parameter int SLOTS       = 64,
	parameter int OBJECT_BITS = 8,
	parameter int COUNT_BITS  = 16,
	localparam int IDX_W      = $clog2(SLOTS)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   func,
	input  wire logic [OBJECT_BITS-1:0] object_number,
	input  wire logic [IDX_W-1:0]       slot_index,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [2:0]                  status,
	output logic [IDX_W-1:0]            slot_out,
	output logic [OBJECT_BITS-1:0]      object_out,
	output logic [COUNT_BITS-1:0]       count_out
);

	ctrl_cmd_t  cmd;
	dp_status_t dp_status;

	rist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	rist_datapath #(
		.SLOTS       (SLOTS),
		.OBJECT_BITS (OBJECT_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.dp_status     (dp_status),
		.func          (func),
		.object_number (object_number),
		.slot_index    (slot_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_out      (slot_out),
		.object_out    (object_out),
		.count_out     (count_out)
	);

endmodule

`default_nettype wire

/* dv/tb_refcounted_inode_slot_table.sv */
// Testbench for refcounted_inode_slot_table: directed and random get/put traffic,
// checked item by item against an in-bench model of the slot table.
// Depends on rist_pkg and the RTL of refcounted_inode_slot_table; reads no files.
module tb_refcounted_inode_slot_table
	import rist_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 64;
	localparam int OBJ_W = 8;
	localparam int IDX_W = 6;
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		logic [2:0]       st;
		logic [IDX_W-1:0] slot;
		logic [OBJ_W-1:0] obj;
		logic [CNT_W-1:0] cnt;
	} slot_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             func = FUNC_GET;
	logic [OBJ_W-1:0] object_number = '0;
	logic [IDX_W-1:0] slot_index = '0;
	logic             out_valid;
	logic             out_ready = 1'b1;
	logic [2:0]       status;
	logic [IDX_W-1:0] slot_out;
	logic [OBJ_W-1:0] object_out;
	logic [CNT_W-1:0] count_out;

	// Model of the table contents, updated as each item is accepted
	logic [OBJ_W-1:0] held_obj [NSLOT];
	logic [CNT_W-1:0] held_cnt [NSLOT];
	slot_result_t     pending_results[$];

	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned stall_left = 0;
	bit          idle_en = 1'b1;

	refcounted_inode_slot_table #(
		.SLOTS(NSLOT),
		.OBJECT_BITS(OBJ_W),
		.COUNT_BITS(CNT_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.object_number(object_number),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.slot_out(slot_out),
		.object_out(object_out),
		.count_out(count_out)
	);

	always #4 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		fail_cnt++;
		if (fail_cnt <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Apply one get or put to the table model and return the result it yields
	function automatic slot_result_t predict_slot_result(input logic f,
			input logic [OBJ_W-1:0] obj, input logic [IDX_W-1:0] idx);
		slot_result_t r;
		int hit_slot;
		int free_slot;
		r = '0;
		hit_slot = -1;
		free_slot = -1;
		if (f == FUNC_GET) begin
			for (int i = 0; i < NSLOT; i++) begin
				if (hit_slot < 0 && held_cnt[i] != 0 && held_obj[i] == obj)
					hit_slot = i;
				if (free_slot < 0 && held_cnt[i] == 0)
					free_slot = i;
			end
			r.obj = obj;
			if (hit_slot >= 0) begin
				// saturate at the top of the count range
				if (held_cnt[hit_slot] != COUNT_MAX)
					held_cnt[hit_slot]++;
				r.st = ST_HIT;
				r.slot = IDX_W'(hit_slot);
				r.cnt = held_cnt[hit_slot];
			end else if (free_slot >= 0) begin
				held_obj[free_slot] = obj;
				held_cnt[free_slot] = CNT_W'(1);
				r.st = ST_LOAD;
				r.slot = IDX_W'(free_slot);
				r.cnt = CNT_W'(1);
			end else begin
				r.st = ST_FULL;
			end
		end else begin
			r.slot = idx;
			if (held_cnt[idx] == 0) begin
				r.st = ST_IGNORED;
			end else begin
				held_cnt[idx]--;
				r.st = (held_cnt[idx] == 0) ? ST_WRITEBACK : ST_STILL_USED;
				r.obj = held_obj[idx];
				r.cnt = held_cnt[idx];
			end
		end
		return r;
	endfunction

	// Send one item, with an optional gap before it; record its result on acceptance
	task automatic issue_req(input logic f, input logic [OBJ_W-1:0] obj,
			input logic [IDX_W-1:0] idx);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		object_number <= obj;
		slot_index <= idx;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_slot_result(f, obj, idx));
	endtask

	// Stall the result channel in random bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_en && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 17);
		out_ready <= (stall_left == 0);
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : chk_results
		slot_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected item: status=%0d slot=%0d obj=%0d cnt=%0d",
					status, slot_out, object_out, count_out));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st || slot_out !== want.slot ||
						object_out !== want.obj || count_out !== want.cnt)
					report_mismatch($sformatf(
						"got status=%0d slot=%0d obj=%0d cnt=%0d, want %0d/%0d/%0d/%0d",
						status, slot_out, object_out, count_out,
						want.st, want.slot, want.obj, want.cnt));
			end
		end
	end

	// Load, hit, release down to writeback, and puts on unused slots
	task automatic test_get_put_basic();
		issue_req(FUNC_GET, 8'd0, 6'd63);
		issue_req(FUNC_GET, 8'd255, 6'd0);
		issue_req(FUNC_GET, 8'd0, 6'd0);
		issue_req(FUNC_PUT, 8'd255, 6'd0);
		issue_req(FUNC_PUT, 8'd0, 6'd0);
		issue_req(FUNC_PUT, 8'd0, 6'd0);
		issue_req(FUNC_PUT, 8'd0, 6'd63);
		issue_req(FUNC_GET, 8'hAA, 6'd21);
		issue_req(FUNC_GET, 8'h55, 6'd42);
		issue_req(FUNC_PUT, 8'd0, 6'd1);
		issue_req(FUNC_PUT, 8'd0, 6'd0);
		issue_req(FUNC_PUT, 8'd0, 6'd2);
	endtask

	// Fill every slot, hit the full table, reuse a freed hole, then drain
	task automatic test_table_full();
		for (int i = 0; i < NSLOT; i++)
			issue_req(FUNC_GET, OBJ_W'(i * 4 + 3), IDX_W'(i));
		issue_req(FUNC_GET, 8'd128, 6'd0);
		issue_req(FUNC_GET, 8'd3, 6'd0);
		issue_req(FUNC_PUT, 8'd0, 6'd40);
		issue_req(FUNC_GET, 8'd128, 6'd0);
		issue_req(FUNC_GET, 8'd129, 6'd0);
		for (int i = 0; i < NSLOT; i++)
			while (held_cnt[i] != 0)
				issue_req(FUNC_PUT, 8'd0, IDX_W'(i));
		issue_req(FUNC_PUT, 8'd0, 6'd63);
	endtask

	// Mixed traffic in phases of varying get/put balance; no new gaps or stall bursts at the end
	task automatic test_random_traffic(input int n_items);
		int get_pct;
		int start;
		int pick;
		logic f;
		logic [OBJ_W-1:0] obj;
		logic [IDX_W-1:0] idx;
		get_pct = 50;
		for (int k = 0; k < n_items; k++) begin
			if (k % 75 == 0)
				get_pct = $urandom_range(25, 90);
			if (k == n_items - 60)
				idle_en = 1'b0;
			obj = OBJ_W'($urandom);
			idx = IDX_W'($urandom);
			f = ($urandom_range(0, 99) < get_pct) ? FUNC_GET : FUNC_PUT;
			// find a slot in use, starting at a random point
			start = $urandom_range(0, NSLOT - 1);
			pick = -1;
			for (int j = 0; j < NSLOT; j++)
				if (pick < 0 && held_cnt[(start + j) % NSLOT] != 0)
					pick = (start + j) % NSLOT;
			if (f == FUNC_GET && pick >= 0 && $urandom_range(0, 1) == 1)
				obj = held_obj[pick];
			if (f == FUNC_PUT && pick >= 0 && $urandom_range(0, 4) != 0)
				idx = IDX_W'(pick);
			issue_req(f, obj, idx);
		end
	endtask

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			held_obj[i] = '0;
			held_cnt[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_get_put_basic();
		test_table_full();
		test_random_traffic(300);
		in_valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
